// ===== rtl/core/uvw_pkg.sv =====
// Shared types and constants of the uvw baseline projection unit.
// Fixed-point coefficients, pipeline latencies and the CORDIC angle function.
// No dependencies.
package uvw_pkg;

  typedef enum logic [1:0] {
    CFG_RA  = 2'd0,
    CFG_DEC = 2'd1,
    CFG_LON = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TIME_W    = 57;
  localparam int unsigned BASE_W    = 32;
  localparam int unsigned COORD_W   = 40;
  localparam int unsigned TRIG_W    = 32;
  localparam int unsigned CORDIC_STEPS = 32;

  localparam int unsigned MUL_LAT    = 3;
  localparam int unsigned GMST_LAT   = 15;
  localparam int unsigned SINCOS_LAT = CORDIC_STEPS + 2;
  localparam int unsigned PROJ_LAT   = 10;

  // turns times 2^64
  localparam logic [63:0] GMST0      = 64'd14371070138404760294;
  localparam logic [63:0] RATE_EXC   = 64'd50505513091326355;
  localparam logic [63:0] QUAD_COEF  = 64'd19878057690962;
  localparam logic [63:0] CUBE_COEF  = 64'd1323713660;
  localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;

  localparam logic [63:0] EPOCH_HALF_DAYS = 64'd103089;
  localparam logic signed [63:0] POLY_SPAN = 64'sh10_0000_0000;
  // floor(n / 36525) = (n * DIV_RECIP) >> 61 for n < 2^45
  localparam logic [63:0] DIV_RECIP = ((64'd1 << 61) + 64'd36524) / 64'd36525;

  localparam logic signed [TRIG_W-1:0] CORDIC_START = 32'sd652032874;
  localparam logic [63:0] PS_PER_MM = 64'd14326468800;

  localparam logic signed [63:0] OUT_MAX = 64'sd549755813887;
  localparam logic signed [63:0] OUT_MIN = -64'sd549755813888;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [63:0]       z;
    logic [1:0]               q;
  } cordic_t;

  // arctan(2^-step) in turns times 2^64, series in Q62 radians
  function automatic logic [63:0] atan_turn(input int unsigned step);
    logic [63:0]  rad;
    logic [63:0]  term;
    logic [127:0] prod;
    int unsigned  e;
    rad  = '0;
    term = '0;
    prod = '0;
    e    = 0;
    if (step == 0) begin
      return 64'd1 << 61;
    end
    for (int unsigned k = 0; k < 32; k++) begin
      e = step * (2 * k + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        rad  = k[0] ? rad - term : rad + term;
      end
    end
    prod = {64'd0, rad} * {64'd0, INV_TWO_PI};
    return prod[125:62];
  endfunction

endpackage

// ===== rtl/core/uvw_baseline_projection_unit.sv =====
// Top level of the uvw baseline projection unit: config registers, valid
// line and the GMST, sin/cos and projection pipelines.
// Uses uvw_pkg, uvw_gmst, uvw_sincos, uvw_delay and uvw_project.
//   port group | dir | handshake            | payload
//   -----------+-----+----------------------+------------------------------------------
//   in         | in  | in_valid_i/in_stall_o | time_mjd_i, baseline_{x,y,z}_i, last_in_set_i
//   out        | out | out_valid_o/out_stall_i | coord_{u,v,w}_o, last_of_set_o
//   cfg        | in  | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// One beat per cycle in each direction while no output beat is held. Data passes the
// sidereal time stages, the 32-step CORDIC pipeline, then projection and ps scaling.
// rst_ni clears valid bits and config registers; data registers are not reset.
// A held output beat freezes the whole pipeline and stalls the input in the same cycle.
module uvw_baseline_projection_unit #(
  parameter int unsigned ANGLE_BITS     = 32,
  parameter int unsigned TIME_FRAC_BITS = 40
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [uvw_pkg::TIME_W-1:0]           time_mjd_i,
  input  logic signed [uvw_pkg::BASE_W-1:0]    baseline_x_i,
  input  logic signed [uvw_pkg::BASE_W-1:0]    baseline_y_i,
  input  logic signed [uvw_pkg::BASE_W-1:0]    baseline_z_i,
  input  logic                                 last_in_set_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [uvw_pkg::COORD_W-1:0]   coord_u_o,
  output logic signed [uvw_pkg::COORD_W-1:0]   coord_v_o,
  output logic signed [uvw_pkg::COORD_W-1:0]   coord_w_o,
  output logic                                 last_of_set_o,
  input  logic                                 cfg_we_i,
  input  logic [uvw_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ANGLE_BITS-1:0]                cfg_wdata_i
);

  localparam int unsigned TrigLat  = uvw_pkg::GMST_LAT + uvw_pkg::SINCOS_LAT;
  localparam int unsigned TotalLat = TrigLat + uvw_pkg::PROJ_LAT;

  logic [ANGLE_BITS-1:0] ra_q, dec_q, lon_q, ha;
  logic [TotalLat-1:0]   vld_q;
  logic                  en;
  logic signed [uvw_pkg::BASE_W-1:0] bx_d, by_d, bz_d;
  logic signed [uvw_pkg::TRIG_W-1:0] ch, sh, cd, sd;

  assign in_stall_o = out_valid_o & out_stall_i;
  assign en         = ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_q  <= '0;
      dec_q <= '0;
      lon_q <= '0;
    end else if (cfg_we_i) begin
      unique case (uvw_pkg::cfg_idx_e'(cfg_idx_i))
        uvw_pkg::CFG_RA:  ra_q  <= cfg_wdata_i;
        uvw_pkg::CFG_DEC: dec_q <= cfg_wdata_i;
        uvw_pkg::CFG_LON: lon_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TotalLat-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[TotalLat-1];

  uvw_gmst #(.ANGLE_BITS(ANGLE_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_gmst (
    .clk_i, .en_i(en), .time_i(time_mjd_i), .ra_i(ra_q), .lon_i(lon_q), .ha_o(ha)
  );

  uvw_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_ha (
    .clk_i, .en_i(en), .ang_i(ha), .cos_o(ch), .sin_o(sh)
  );

  // the user changes declination only while the pipe is empty; not enforced by the block
  uvw_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_dec (
    .clk_i, .en_i(en), .ang_i(dec_q), .cos_o(cd), .sin_o(sd)
  );

  uvw_delay #(.W(3*uvw_pkg::BASE_W), .N(TrigLat)) u_dly_base (
    .clk_i, .en_i(en), .d_i({baseline_x_i, baseline_y_i, baseline_z_i}),
    .q_o({bx_d, by_d, bz_d})
  );

  uvw_delay #(.W(1), .N(TotalLat)) u_dly_last (
    .clk_i, .en_i(en), .d_i(last_in_set_i), .q_o(last_of_set_o)
  );

  uvw_project u_project (
    .clk_i, .en_i(en),
    .bx_i(bx_d), .by_i(by_d), .bz_i(bz_d),
    .ch_i(ch), .sh_i(sh), .cd_i(cd), .sd_i(sd),
    .u_o(coord_u_o), .v_o(coord_v_o), .w_o(coord_w_o)
  );

endmodule

// ===== rtl/core/uvw_mul.sv =====
// Pipelined 64x64 signed multiplier, three register stages.
// Built from four 32x32 partial products. No dependencies.
module uvw_mul (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [63:0]  a_i,
  input  logic signed [63:0]  b_i,
  output logic signed [127:0] p_o
);

  logic [63:0]         pll_q;
  logic signed [64:0]  plh_q;
  logic signed [64:0]  phl_q;
  logic signed [63:0]  phh_q;
  logic signed [127:0] slo_q;
  logic signed [127:0] shi_q;
  logic signed [127:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q <= a_i[31:0] * b_i[31:0];
      plh_q <= $signed({1'b0, a_i[31:0]}) * $signed(b_i[63:32]);
      phl_q <= $signed(a_i[63:32]) * $signed({1'b0, b_i[31:0]});
      phh_q <= $signed(a_i[63:32]) * $signed(b_i[63:32]);
      slo_q <= $signed({64'd0, pll_q}) + ($signed({{63{plh_q[64]}}, plh_q}) <<< 32);
      shi_q <= $signed({{63{phl_q[64]}}, phl_q}) + ($signed({{64{phh_q[63]}}, phh_q}) <<< 32);
      p_q   <= slo_q + (shi_q <<< 32);
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/uvw_delay.sv =====
// Enabled shift line of N registers for side data of the pipeline.
// No dependencies.
module uvw_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int unsigned i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

// ===== rtl/core/uvw_gmst.sv =====
// Sidereal time polynomial and hour angle, GMST_LAT register stages.
// Uses uvw_pkg, uvw_mul, uvw_delay.
module uvw_gmst #(
  parameter int unsigned ANGLE_BITS     = 32,
  parameter int unsigned TIME_FRAC_BITS = 40
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [uvw_pkg::TIME_W-1:0]  time_i,
  input  logic [ANGLE_BITS-1:0]       ra_i,
  input  logic [ANGLE_BITS-1:0]       lon_i,
  output logic [ANGLE_BITS-1:0]       ha_o
);

  localparam logic [63:0] EpochOff = uvw_pkg::EPOCH_HALF_DAYS << (TIME_FRAC_BITS - 1);
  localparam logic [63:0] HalfLsb  = 64'd1 << (63 - ANGLE_BITS);

  logic signed [63:0]  ds_q;
  logic [63:0]         lin_q, lin_r10;
  logic signed [63:0]  dq;
  logic [36:0]         mag;
  logic                neg_d, neg_q, neg_r5;
  logic [44:0]         absn_q;
  logic signed [127:0] e_p, div_p, t3_p, quad_p, cube_p;
  logic [63:0]         eterm_r10;
  logic [28:0]         quo;
  logic signed [29:0]  t_q, t_r7;
  logic signed [59:0]  tt_q;
  logic signed [35:0]  t2;
  logic signed [39:0]  t3;
  logic [63:0]         part_q, part_r13;
  logic [63:0]         g_q;
  logic [63:0]         ha_sum;
  logic [ANGLE_BITS-1:0] ha_q;

  // time clamp for the polynomial: |dq| <= 2^36 in Q16 days, i.e. 2^20 days
  always_comb begin
    dq    = ds_q >>> (TIME_FRAC_BITS - 16);
    neg_d = dq[63];
    if (dq > uvw_pkg::POLY_SPAN || dq < -uvw_pkg::POLY_SPAN) begin
      mag = 37'h10_0000_0000;
    end else if (neg_d) begin
      mag = 37'(-dq);
    end else begin
      mag = dq[36:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ds_q   <= $signed({7'd0, time_i} - EpochOff);
      lin_q  <= uvw_pkg::GMST0 + (ds_q << (64 - TIME_FRAC_BITS));
      absn_q <= {mag, 8'd0};
      neg_q  <= neg_d;
      t_q    <= neg_r5 ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      tt_q   <= t_q * t_q;
      part_q <= lin_r10 + eterm_r10 + quad_p[87:24];
      g_q    <= part_r13 - cube_p[87:24];
      ha_q   <= ha_sum[63 -: ANGLE_BITS];
    end
  end

  assign quo    = div_p[89:61];
  assign t2     = tt_q[59:24];
  assign t3     = t3_p[63:24];
  assign ha_sum = g_q + ({lon_i, {(64-ANGLE_BITS){1'b0}}})
                - ({ra_i, {(64-ANGLE_BITS){1'b0}}}) + HalfLsb;
  assign ha_o   = ha_q;

  uvw_mul u_mul_rate (
    .clk_i, .en_i, .a_i(ds_q), .b_i($signed(uvw_pkg::RATE_EXC)), .p_o(e_p)
  );

  uvw_mul u_mul_div (
    .clk_i, .en_i, .a_i($signed({19'd0, absn_q})), .b_i($signed(uvw_pkg::DIV_RECIP)),
    .p_o(div_p)
  );

  uvw_mul u_mul_cube3 (
    .clk_i, .en_i, .a_i(64'(t2)), .b_i(64'(t_r7)), .p_o(t3_p)
  );

  uvw_mul u_mul_quad (
    .clk_i, .en_i, .a_i($signed(uvw_pkg::QUAD_COEF)), .b_i(64'(t2)), .p_o(quad_p)
  );

  uvw_mul u_mul_cube (
    .clk_i, .en_i, .a_i($signed(uvw_pkg::CUBE_COEF)), .b_i(64'(t3)), .p_o(cube_p)
  );

  uvw_delay #(.W(64), .N(8)) u_dly_lin (
    .clk_i, .en_i, .d_i(lin_q), .q_o(lin_r10)
  );

  uvw_delay #(.W(64), .N(6)) u_dly_eterm (
    .clk_i, .en_i, .d_i(e_p[TIME_FRAC_BITS+63:TIME_FRAC_BITS]), .q_o(eterm_r10)
  );

  uvw_delay #(.W(1), .N(3)) u_dly_neg (
    .clk_i, .en_i, .d_i(neg_q), .q_o(neg_r5)
  );

  uvw_delay #(.W(30), .N(1)) u_dly_t (
    .clk_i, .en_i, .d_i(t_q), .q_o(t_r7)
  );

  uvw_delay #(.W(64), .N(2)) u_dly_part (
    .clk_i, .en_i, .d_i(part_q), .q_o(part_r13)
  );

endmodule

// ===== rtl/core/uvw_cordic_step.sv =====
// One registered CORDIC rotation step; STEP selects shift and angle.
// Uses uvw_pkg.
module uvw_cordic_step #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  uvw_pkg::cordic_t d_i,
  output uvw_pkg::cordic_t q_o
);

  localparam logic [63:0] AtanTurn = uvw_pkg::atan_turn(STEP);

  uvw_pkg::cordic_t nxt, st_q;
  logic signed [uvw_pkg::TRIG_W-1:0] dx, dy;

  always_comb begin
    dx  = d_i.y >>> STEP;
    dy  = d_i.x >>> STEP;
    nxt = d_i;
    if (!d_i.z[63]) begin
      nxt.x = d_i.x - dx;
      nxt.y = d_i.y + dy;
      nxt.z = d_i.z - $signed(AtanTurn);
    end else begin
      nxt.x = d_i.x + dx;
      nxt.y = d_i.y - dy;
      nxt.z = d_i.z + $signed(AtanTurn);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= nxt;
    end
  end

  assign q_o = st_q;

endmodule

// ===== rtl/core/uvw_sincos.sv =====
// Sine and cosine of an angle in turns: quadrant reduction, 32 CORDIC steps,
// quadrant fix-up. SINCOS_LAT stages. Uses uvw_pkg, uvw_cordic_step.
module uvw_sincos #(
  parameter int unsigned ANGLE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [ANGLE_BITS-1:0]             ang_i,
  output logic signed [uvw_pkg::TRIG_W-1:0] cos_o,
  output logic signed [uvw_pkg::TRIG_W-1:0] sin_o
);

  uvw_pkg::cordic_t st [uvw_pkg::CORDIC_STEPS+1];
  uvw_pkg::cordic_t pre_d, pre_q, fin;
  logic [63:0] ang64, ang_rot;
  logic signed [uvw_pkg::TRIG_W-1:0] cos_d, sin_d, cos_q, sin_q;

  always_comb begin
    ang64   = {ang_i, {(64-ANGLE_BITS){1'b0}}};
    ang_rot = ang64 + 64'h2000_0000_0000_0000;
    pre_d.q = ang_rot[63:62];
    pre_d.z = $signed(ang64 - {ang_rot[63:62], 62'd0});
    pre_d.x = uvw_pkg::CORDIC_START;
    pre_d.y = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_d;
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign st[0] = pre_q;

  for (genvar i = 0; i < uvw_pkg::CORDIC_STEPS; i++) begin : g_step
    uvw_cordic_step #(.STEP(i)) u_step (
      .clk_i, .en_i, .d_i(st[i]), .q_o(st[i+1])
    );
  end

  assign fin = st[uvw_pkg::CORDIC_STEPS];

  always_comb begin
    unique case (fin.q)
      2'd0: begin cos_d = fin.x;  sin_d = fin.y;  end
      2'd1: begin cos_d = -fin.y; sin_d = fin.x;  end
      2'd2: begin cos_d = -fin.x; sin_d = -fin.y; end
      2'd3: begin cos_d = fin.y;  sin_d = -fin.x; end
    endcase
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ===== rtl/core/uvw_project.sv =====
// Baseline rotation onto u, v, w and conversion to picoseconds with
// rounding and saturation. PROJ_LAT stages. Uses uvw_pkg, uvw_mul, uvw_delay.
module uvw_project (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [uvw_pkg::BASE_W-1:0]  bx_i,
  input  logic signed [uvw_pkg::BASE_W-1:0]  by_i,
  input  logic signed [uvw_pkg::BASE_W-1:0]  bz_i,
  input  logic signed [uvw_pkg::TRIG_W-1:0]  ch_i,
  input  logic signed [uvw_pkg::TRIG_W-1:0]  sh_i,
  input  logic signed [uvw_pkg::TRIG_W-1:0]  cd_i,
  input  logic signed [uvw_pkg::TRIG_W-1:0]  sd_i,
  output logic signed [uvw_pkg::COORD_W-1:0] u_o,
  output logic signed [uvw_pkg::COORD_W-1:0] v_o,
  output logic signed [uvw_pkg::COORD_W-1:0] w_o
);

  logic signed [63:0] bxsh_q, bych_q, bxch_q, bysh_q, bzcd_q, bzsd_q;
  logic signed [63:0] u_q, xr_q, v_q, w_q;
  logic signed [63:0] bzcd_r5, bzsd_r5, u_r6;
  logic signed [uvw_pkg::TRIG_W-1:0] cd_r2, sd_r2;
  logic signed [127:0] vs_p, wc_p;
  logic signed [63:0]  mm [3];
  logic signed [127:0] ps_p [3];
  logic signed [uvw_pkg::COORD_W-1:0] out_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bxsh_q <= bx_i * sh_i;
      bych_q <= by_i * ch_i;
      bxch_q <= bx_i * ch_i;
      bysh_q <= by_i * sh_i;
      bzcd_q <= bz_i * cd_i;
      bzsd_q <= bz_i * sd_i;
      u_q    <= bxsh_q + bych_q;
      xr_q   <= bxch_q - bysh_q;
      v_q    <= bzcd_r5 - vs_p[93:30];
      w_q    <= wc_p[93:30] + bzsd_r5;
    end
  end

  uvw_delay #(.W(2*uvw_pkg::TRIG_W), .N(2)) u_dly_dec (
    .clk_i, .en_i, .d_i({cd_i, sd_i}), .q_o({cd_r2, sd_r2})
  );

  uvw_delay #(.W(128), .N(4)) u_dly_bz (
    .clk_i, .en_i, .d_i({bzcd_q, bzsd_q}), .q_o({bzcd_r5, bzsd_r5})
  );

  uvw_delay #(.W(64), .N(4)) u_dly_u (
    .clk_i, .en_i, .d_i(u_q), .q_o(u_r6)
  );

  uvw_mul u_mul_vs (
    .clk_i, .en_i, .a_i(xr_q), .b_i(64'(sd_r2)), .p_o(vs_p)
  );

  uvw_mul u_mul_wc (
    .clk_i, .en_i, .a_i(xr_q), .b_i(64'(cd_r2)), .p_o(wc_p)
  );

  assign mm[0] = u_r6;
  assign mm[1] = v_q;
  assign mm[2] = w_q;

  for (genvar l = 0; l < 3; l++) begin : g_ps
    logic signed [63:0] r, rr, h;

    uvw_mul u_mul_ps (
      .clk_i, .en_i, .a_i(mm[l]), .b_i($signed(uvw_pkg::PS_PER_MM)), .p_o(ps_p[l])
    );

    // round half up, then clip to the output range
    always_comb begin
      r  = ps_p[l][124:61];
      rr = r + 64'sd1;
      h  = rr >>> 1;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (h > uvw_pkg::OUT_MAX) begin
          out_q[l] <= uvw_pkg::OUT_MAX[uvw_pkg::COORD_W-1:0];
        end else if (h < uvw_pkg::OUT_MIN) begin
          out_q[l] <= uvw_pkg::OUT_MIN[uvw_pkg::COORD_W-1:0];
        end else begin
          out_q[l] <= h[uvw_pkg::COORD_W-1:0];
        end
      end
    end
  end

  assign u_o = out_q[0];
  assign v_o = out_q[1];
  assign w_o = out_q[2];

endmodule

// ===== rtl/core/uvw_checker.sv =====
// Port-level assertions for uvw_baseline_projection_unit, bound to the top.
// Uses uvw_pkg.
module uvw_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [uvw_pkg::COORD_W-1:0] coord_u_o,
  input logic signed [uvw_pkg::COORD_W-1:0] coord_v_o,
  input logic signed [uvw_pkg::COORD_W-1:0] coord_w_o,
  input logic                               last_of_set_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable({coord_u_o, coord_v_o, coord_w_o, last_of_set_o}))
    else $error("stalled output beat changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to a held output beat");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind uvw_baseline_projection_unit uvw_checker u_chk (.*);
